FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL. They compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CHK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CHK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

FILE: hdl/grp_pkg.sv
package grp_pkg;

  localparam int CoefW     = 64;
  localparam int CountW    = 32;
  localparam int ExpFieldW = 16;
  localparam int DigitW    = 4;
  localparam int NumDigits = CoefW / DigitW;
  localparam int DigCntW   = $clog2(NumDigits);

  typedef struct packed {
    logic signed [CoefW-1:0]     base_rational;
    logic signed [CoefW-1:0]     base_phi;
    logic        [ExpFieldW-1:0] exponent;
  } in_word_t;

  typedef struct packed {
    logic signed [CoefW-1:0]  power_rational;
    logic signed [CoefW-1:0]  power_phi;
    logic        [CountW-1:0] mult_count;
  } out_word_t;

  typedef struct packed {
    logic start;
  } mul_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

FILE: hdl/grp_ring_mul.sv
// Digit-serial product in Z[phi]: base times multiplier, multiplier digits taken
// most significant first, one digit per cycle (Horner form, modulo 2^CoefW).
module grp_ring_mul
  import grp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mul_ctrl_t         ctrl_i,
  input  logic [CoefW-1:0]  base_rat_i,
  input  logic [CoefW-1:0]  base_ph_i,
  input  logic [CoefW-1:0]  mul_rat_i,
  input  logic [CoefW-1:0]  mul_ph_i,
  output mul_stat_t         stat_o,
  output logic [CoefW-1:0]  prod_rat_o,
  output logic [CoefW-1:0]  prod_ph_o
);

  logic [CoefW-1:0]   mr_q, mr_d, mp_q, mp_d;
  logic [CoefW-1:0]   pr_q, pr_d, pp_q, pp_d;
  logic [DigCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [DigitW-1:0]  dr, dp;

  assign dr = mr_q[CoefW-1 -: DigitW];
  assign dp = mp_q[CoefW-1 -: DigitW];

  // rat += br*dr + bp*dp ; ph += br*dp + bp*(dr + dp), from phi^2 = phi + 1.
  always_comb begin
    mr_d = mr_q << DigitW;
    mp_d = mp_q << DigitW;
    pr_d = (pr_q << DigitW) + base_rat_i * CoefW'(dr) + base_ph_i * CoefW'(dp);
    pp_d = (pp_q << DigitW) + base_rat_i * CoefW'(dp)
         + base_ph_i * (CoefW'(dr) + CoefW'(dp));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !ctrl_i.start && busy_q && (cnt_q == DigCntW'(NumDigits - 1));
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DigCntW'(1);
        if (cnt_q == DigCntW'(NumDigits - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      mr_q <= mul_rat_i;
      mp_q <= mul_ph_i;
      pr_q <= '0;
      pp_q <= '0;
    end else if (busy_q) begin
      mr_q <= mr_d;
      mp_q <= mp_d;
      pr_q <= pr_d;
      pp_q <= pp_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_rat_o  = pr_q;
  assign prod_ph_o   = pp_q;

endmodule

FILE: hdl/golden_ring_power_top.sv
// Raises a + b*phi in Z[phi] (phi*phi = phi + 1) to a power n, modulo 2^64.
// Input channel in_valid_i / in_stall_o carries a word with base_rational,
// base_phi and exponent; the output channel out_valid_o / out_stall_i returns
// power_rational, power_phi and mult_count, the number of ring products made
// since reset including this word's n (wrapping at 2^32). One result per word.
// The low EXP_WIDTH bits of the exponent are used.
// Each ring product runs through a digit-serial multiplier that consumes one
// 4-bit digit of the accumulator per cycle, 16 digits, with the start strobe
// and the done strobe each registered. n = 0 gives 1 + 0*phi with no product.
// One word is worked on at a time; the next word is taken when the previous
// result has moved to the output register, even while that result is stalled.
// A stalled result holds in the output register and the finished product
// waits in the block until the register frees.
// Reset clears the product count, empties the output and returns to idle.
`include "assert_macros.svh"

module golden_ring_power_top
  import grp_pkg::*;
#(
  parameter int EXP_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_DONE
  } state_e;

  state_e                state_q;
  logic                  start_q, start_d;
  logic [EXP_WIDTH-1:0]  remaining_q;
  logic [EXP_WIDTH-1:0]  exp_n;
  logic [CountW-1:0]     count_q;
  logic [CoefW-1:0]      base_rat_q, base_ph_q, acc_rat_q, acc_ph_q;
  logic                  out_valid_q;
  out_word_t             out_q;
  logic                  in_acc, out_free, load_out;
  mul_ctrl_t             mul_ctrl;
  mul_stat_t             mul_stat;
  logic [CoefW-1:0]      prod_rat, prod_ph;

  generate
    if (EXP_WIDTH <= ExpFieldW) begin : g_exp_trunc
      assign exp_n = in_data_i.exponent[EXP_WIDTH-1:0];
    end else begin : g_exp_ext
      assign exp_n = EXP_WIDTH'(in_data_i.exponent);
    end
  endgenerate

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == S_DONE) && out_free;
  assign start_d    = (in_acc && exp_n != '0)
                   || (state_q == S_WAIT && mul_stat.done
                       && remaining_q != EXP_WIDTH'(1));
  assign mul_ctrl.start = start_q;

  grp_ring_mul u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mul_ctrl),
    .base_rat_i (base_rat_q),
    .base_ph_i  (base_ph_q),
    .mul_rat_i  (acc_rat_q),
    .mul_ph_i   (acc_ph_q),
    .stat_o     (mul_stat),
    .prod_rat_o (prod_rat),
    .prod_ph_o  (prod_ph)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      remaining_q <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= start_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            remaining_q <= exp_n;
            if (exp_n == '0) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (mul_stat.done) begin
            count_q     <= count_q + CountW'(1);
            remaining_q <= remaining_q - EXP_WIDTH'(1);
            if (remaining_q == EXP_WIDTH'(1)) begin
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Accumulator and result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      base_rat_q <= in_data_i.base_rational;
      base_ph_q  <= in_data_i.base_phi;
      acc_rat_q  <= CoefW'(1);
      acc_ph_q   <= '0;
    end else if (state_q == S_WAIT && mul_stat.done) begin
      acc_rat_q <= prod_rat;
      acc_ph_q  <= prod_ph;
    end
    if (load_out) begin
      out_q.power_rational <= acc_rat_q;
      out_q.power_phi      <= acc_ph_q;
      out_q.mult_count     <= count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_CHK(a_accept_leaves_idle, clk_i, rst_ni, in_acc |=> state_q != S_IDLE)
  `ASSERT_NEVER(a_done_outside_wait, clk_i, rst_ni, mul_stat.done && state_q != S_WAIT)
  `ASSERT_CHK(a_count_steps, clk_i, rst_ni, mul_stat.done |=> count_q == $past(count_q) + CountW'(1))
  `ASSERT_NEVER(a_start_while_busy, clk_i, rst_ni, start_q && mul_stat.busy)

endmodule

FILE: dv/ring_power_scoreboard_pkg.sv
`timescale 1ns / 100ps

package ring_power_scoreboard_pkg;
  import grp_pkg::*;

  class ring_power_scoreboard;
    int unsigned exp_width;
    bit [CountW-1:0] product_total;
    out_word_t expected_powers[$];
    int unsigned mismatches;

    function new(int unsigned exp_w);
      exp_width = exp_w;
      product_total = '0;
      mismatches = 0;
    endfunction

    // Works out base^n in Z[phi] by repeated ring products, all modulo 2^64.
    function void note_operand(in_word_t w);
      bit [CoefW-1:0] base_r;
      bit [CoefW-1:0] base_p;
      bit [CoefW-1:0] acc_r;
      bit [CoefW-1:0] acc_p;
      bit [CoefW-1:0] next_r;
      bit [CoefW-1:0] next_p;
      bit [CoefW-1:0] phi_sq;
      bit [31:0] steps;
      out_word_t expected;
      base_r = w.base_rational;
      base_p = w.base_phi;
      steps = 32'(w.exponent) & ((32'd1 << exp_width) - 32'd1);
      acc_r = CoefW'(1);
      acc_p = '0;
      repeat (steps) begin
        // The phi*phi term folds back into both coefficients.
        phi_sq = base_p * acc_p;
        next_r = base_r * acc_r + phi_sq;
        next_p = base_r * acc_p + base_p * acc_r + phi_sq;
        acc_r = next_r;
        acc_p = next_p;
      end
      product_total = product_total + steps[CountW-1:0];
      expected.power_rational = acc_r;
      expected.power_phi = acc_p;
      expected.mult_count = product_total;
      expected_powers.push_back(expected);
    endfunction

    function void check_power(out_word_t got);
      out_word_t want;
      if (expected_powers.size() == 0) begin
        $display("%0t: result word with nothing expected: %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_powers.pop_front();
      if (got.power_rational !== want.power_rational) begin
        $display("%0t: power_rational expected %h got %h", $time,
                 want.power_rational, got.power_rational);
        mismatches++;
      end
      if (got.power_phi !== want.power_phi) begin
        $display("%0t: power_phi expected %h got %h", $time,
                 want.power_phi, got.power_phi);
        mismatches++;
      end
      if (got.mult_count !== want.mult_count) begin
        $display("%0t: mult_count expected %0d got %0d", $time,
                 want.mult_count, got.mult_count);
        mismatches++;
      end
    endfunction
  endclass

endpackage

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import grp_pkg::*;
  import ring_power_scoreboard_pkg::*;

  localparam int ExpWidth = 16;
  localparam int HoldCycles = 400;
  localparam int RandomWords = 75;
  localparam int QuietWords = 15;
  localparam longint unsigned CycleLimit = 64'd8_000_000;
  localparam logic signed [CoefW-1:0] CoefMin = {1'b1, {(CoefW-1){1'b0}}};
  localparam logic signed [CoefW-1:0] CoefMax = {1'b0, {(CoefW-1){1'b1}}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  bit quiet = 1'b0;
  bit hold_request = 1'b0;

  ring_power_scoreboard powers = new(ExpWidth);

  golden_ring_power_top #(
    .EXP_WIDTH(ExpWidth)
  ) DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall === 1'b0) begin
      powers.note_operand(in_word);
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      powers.check_power(out_word);
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    int unsigned span;
    logic level;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        level = 1'b1;
        span = HoldCycles;
      end else if (quiet) begin
        level = 1'b0;
        span = 1;
      end else begin
        level = ($urandom_range(0, 2) == 0);
        span = $urandom_range(1, 19);
      end
      out_stall <= level;
      repeat (span) @(posedge clk);
    end
  end

  initial begin
    longint unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic in_word_t make_word(logic signed [CoefW-1:0] a,
                                         logic signed [CoefW-1:0] b,
                                         logic [ExpFieldW-1:0] n);
    in_word_t w;
    w.base_rational = a;
    w.base_phi = b;
    w.exponent = n;
    return w;
  endfunction

  function automatic logic signed [CoefW-1:0] random_coef();
    case ($urandom_range(0, 7))
      0: return CoefW'(longint'($urandom_range(0, 6)) - 64'sd3);
      1: begin
        case ($urandom_range(0, 3))
          0: return CoefMin;
          1: return CoefMax;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly short powers; long ones are costly, one digit-serial product per step.
  function automatic logic [ExpFieldW-1:0] random_exponent();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return ExpFieldW'($urandom_range(0, 31));
    if (pick < 95) return ExpFieldW'($urandom_range(32, 255));
    return ExpFieldW'($urandom_range(256, 1023));
  endfunction

  task automatic send_word(in_word_t w);
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic stop_sending();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (powers.expected_powers.size() != 0) @(posedge clk);
  endtask

  initial begin
    int i;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero exponent, overflow of both coefficients, signs and the longest power.
    send_word(make_word(0, 0, 0));
    send_word(make_word(CoefMin, CoefMax, 0));
    send_word(make_word(3, 5, 1));
    send_word(make_word(1, 1, 20));
    send_word(make_word(0, 1, 30));
    send_word(make_word(-1, 0, 3));
    send_word(make_word(-1, -1, 7));
    send_word(make_word(CoefMax, CoefMax, 2));
    send_word(make_word(CoefMin, CoefMin, 2));
    send_word(make_word(CoefMin, 0, 1));
    send_word(make_word(0, CoefMin, 1));
    send_word(make_word(CoefMax, CoefMin, 5));
    send_word(make_word(2, 0, 64));
    send_word(make_word(0, 1, 100));
    send_word(make_word(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 16'h00ff));
    send_word(make_word(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 16'h0100));
    send_word(make_word(1, 0, 1000));
    send_word(make_word(random_coef(), random_coef(), 16'hffff));
    send_word(make_word(-3, 2, 0));
    stop_sending();
    wait_drained();

    // Hold the output off long enough that the block backs up into its input.
    hold_request = 1'b1;
    while (hold_request) @(posedge clk);
    for (i = 0; i < 6; i++) begin
      send_word(make_word(random_coef(), random_coef(),
                          ExpFieldW'($urandom_range(0, 3))));
    end
    stop_sending();
    wait_drained();

    for (i = 0; i < RandomWords; i++) begin
      if (i == RandomWords - QuietWords) quiet = 1'b1;
      send_word(make_word(random_coef(), random_coef(), random_exponent()));
    end
    stop_sending();
    wait_drained();
    repeat (40) @(posedge clk);

    if (powers.mismatches == 0 && powers.expected_powers.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
